// ===== hw/rtl/fcca_pkg.sv =====
// Package with the shared types, register indexes and code tables of the fault counter aggregator.
`timescale 1ns / 1ps

package fcca_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int TBL_IDX_W = 5;
    localparam int WORD_W = 64;
    localparam int REL_W = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_VARIANT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL = 2'd1;

    localparam logic [1:0] VAR_FIRST = 2'd0;
    localparam logic [1:0] VAR_SECOND = 2'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        CLS_RUN,
        CLS_BLK,
        CLS_LOCK
    } class_t;

    typedef struct packed {
        logic             is_read;
        logic             raise;
        logic             lock;
        logic             blk;
        logic [REL_W-1:0] rel;
    } cmd_t;

    localparam logic [WORD_W-1:0] BLK_CODE [TABLE_DEPTH] = '{
        64'h2, 64'h4, 64'h10, 64'h40, 64'h100, 64'h400, 64'h1000, 64'h4000,
        64'h10000, 64'h40000, 64'h100000, 64'h400000,
        64'h1000000, 64'h4000000, 64'h10000000, 64'h40000000,
        64'h100000000, 64'h400000000, 64'h1000000000, 64'h0,
        64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0,
        64'h0, 64'h0, 64'h0, 64'h4000000000000000
    };

    localparam logic [WORD_W-1:0] LOCK_CODE_V0 [TABLE_DEPTH] = '{
        64'h2, 64'h8, 64'h20, 64'h80, 64'h200, 64'h800, 64'h2000, 64'h8000,
        64'h20000, 64'h80000, 64'h200000, 64'h800000,
        64'h2000000, 64'h8000000, 64'h20000000, 64'h80000000,
        64'h200000000, 64'h800000000, 64'h2000000000, 64'h4000000000,
        64'h10000000000, 64'h40000000000, 64'h100000000000, 64'h400000000000,
        64'h1000000000000, 64'h4000000000000, 64'h10000000000000, 64'h40000000000000,
        64'h100000000000000, 64'h400000000000000, 64'h1000000000000000, 64'h0
    };

    localparam logic [WORD_W-1:0] RUN_CODE_V1 [TABLE_DEPTH] = '{
        64'h1, 64'h8, 64'h20, 64'h80, 64'h200, 64'h800, 64'h2000, 64'h8000,
        64'h20000, 64'h80000, 64'h200000, 64'h800000,
        64'h2000000, 64'h8000000, 64'h20000000, 64'h80000000,
        64'h200000000, 64'h800000000, 64'h2000000000, 64'h4000000000,
        64'h10000000000, 64'h40000000000, 64'h100000000000, 64'h400000000000,
        64'h1000000000000, 64'h4000000000000, 64'h10000000000000, 64'h40000000000000,
        64'h100000000000000, 64'h400000000000000, 64'h1000000000000000, 64'h0
    };

    localparam logic [WORD_W-1:0] LOCK_CODE_V1 [TABLE_DEPTH] = '{
        64'h2, 64'hC, 64'h30, 64'hC0, 64'h300, 64'hC00, 64'h3000, 64'hC000,
        64'h30000, 64'hC0000, 64'h300000, 64'hC00000,
        64'h3000000, 64'hC000000, 64'h30000000, 64'hC0000000,
        64'h300000000, 64'hC00000000, 64'h3000000000, 64'h8000000000,
        64'h20000000000, 64'h80000000000, 64'h200000000000, 64'h800000000000,
        64'h2000000000000, 64'h8000000000000, 64'h20000000000000, 64'h80000000000000,
        64'h200000000000000, 64'h800000000000000, 64'h2000000000000000, 64'h0
    };

    function automatic logic [WORD_W-1:0] code_lock(input logic [1:0] variant,
                                                    input logic [TBL_IDX_W-1:0] i);
        logic [WORD_W-1:0] c;
        case (variant)
            VAR_FIRST:  c = LOCK_CODE_V0[i];
            VAR_SECOND: c = LOCK_CODE_V1[i];
            default:    c = '0;
        endcase
        return c;
    endfunction

    function automatic logic [WORD_W-1:0] code_run(input logic [1:0] variant,
                                                   input logic [TBL_IDX_W-1:0] i);
        logic [WORD_W-1:0] c;
        case (variant)
            VAR_FIRST:  c = (i == '0) ? 64'h1 : 64'h0;
            VAR_SECOND: c = RUN_CODE_V1[i];
            default:    c = '0;
        endcase
        return c;
    endfunction

    function automatic logic [WORD_W-1:0] code_blk(input logic [1:0] variant,
                                                   input logic [TBL_IDX_W-1:0] i);
        logic [WORD_W-1:0] c;
        case (variant)
            VAR_FIRST:  c = BLK_CODE[i];
            VAR_SECOND: c = BLK_CODE[i];
            default:    c = '0;
        endcase
        return c;
    endfunction

endpackage

// ===== hw/rtl/fault_class_counter_aggregator.sv =====
// Top level of the fault class counter aggregator: sequencer, configuration and result register.
//
// Usage: drive the item fields and pulse start while busy is low; the item is
// taken at that clock edge. action 0 is a fault event that updates counters
// and gives no result; action 1 is a read that gives one status_word.
// One shared step unit visits the signals one per cycle, so an item occupies
// the block for a sweep over all NUM_SIGNALS signals. After the sweep an
// event returns the block to idle, while a read enters a done state in which
// done is high for exactly one cycle and status_word holds the result; the
// result is a transfer at the edge that ends that cycle. The receiver cannot
// stall the block.
// Configuration: write_enable, write_index and write_data write the variant
// (index 0) or the normal word (index 1) at a clock edge; other indexes are
// ignored. Writes are to be made only while busy is low; the block itself
// does not enforce this.
// Reset clears all counters, the variant, the normal word and the sequencer.
`timescale 1ns / 1ps

module fault_class_counter_aggregator #(
    parameter int NUM_SIGNALS = 32,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              action,
    input  logic [31:0]                       signal_mask,
    input  logic                              fault_active,
    input  logic                              lock_class,
    input  logic                              blocked_fault,
    input  logic [fcca_pkg::REL_W-1:0]        release_count,
    output logic                              done,
    output logic [fcca_pkg::WORD_W-1:0]       status_word,
    input  logic                              write_enable,
    input  logic [fcca_pkg::CFG_IDX_W-1:0]    write_index,
    input  logic [fcca_pkg::WORD_W-1:0]       write_data
);

    localparam int IDX_W = (NUM_SIGNALS > 1) ? $clog2(NUM_SIGNALS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SIGNALS - 1);

    fcca_pkg::state_t               state_reg, state_next;
    fcca_pkg::cmd_t                 cmd_reg, cmd_next;
    logic [NUM_SIGNALS-1:0]         mask_reg, mask_next;
    logic [IDX_W-1:0]               idx_reg, idx_next;
    logic [fcca_pkg::WORD_W-1:0]    acc_reg, acc_next;
    logic [1:0]                     variant_reg;
    logic [fcca_pkg::WORD_W-1:0]    normal_reg;

    logic                           accept;
    logic                           last;
    logic                           wr_en;
    fcca_pkg::class_t               wr_class;
    logic [COUNT_WIDTH-1:0]         wr_data;
    logic [COUNT_WIDTH-1:0]         cnt_run;
    logic [COUNT_WIDTH-1:0]         cnt_blk;
    logic [COUNT_WIDTH-1:0]         cnt_lock;
    logic [fcca_pkg::WORD_W-1:0]    step_acc;
    logic                           sweeping;

    assign accept   = start && !busy;
    assign last     = (idx_reg == LAST_IDX);
    assign sweeping = (state_reg == fcca_pkg::ST_SWEEP);

    fcca_count_bank #(
        .NUM_SIGNALS (NUM_SIGNALS),
        .COUNT_WIDTH (COUNT_WIDTH),
        .IDX_W       (IDX_W)
    ) u_bank (
        .clk      (clk),
        .rst_n    (rst_n),
        .idx      (idx_reg),
        .wr_en    (wr_en && sweeping),
        .wr_class (wr_class),
        .wr_data  (wr_data),
        .rd_run   (cnt_run),
        .rd_blk   (cnt_blk),
        .rd_lock  (cnt_lock)
    );

    fcca_step_unit #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .IDX_W       (IDX_W)
    ) u_step (
        .cmd         (cmd_reg),
        .mask_bit    (mask_reg[idx_reg]),
        .is_cert     (last),
        .idx         (idx_reg),
        .variant     (variant_reg),
        .normal_word (normal_reg),
        .acc_in      (acc_reg),
        .cnt_run     (cnt_run),
        .cnt_blk     (cnt_blk),
        .cnt_lock    (cnt_lock),
        .wr_en       (wr_en),
        .wr_class    (wr_class),
        .wr_data     (wr_data),
        .acc_out     (step_acc)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            variant_reg <= '0;
            normal_reg  <= '0;
        end
        else if (write_enable)
        begin
            case (write_index)
                fcca_pkg::REG_VARIANT: variant_reg <= write_data[1:0];
                fcca_pkg::REG_NORMAL:  normal_reg  <= write_data;
                default:               variant_reg <= variant_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fcca_pkg::ST_IDLE:
            begin
                if (start)
                    state_next = fcca_pkg::ST_SWEEP;
            end
            fcca_pkg::ST_SWEEP:
            begin
                if (last)
                    state_next = cmd_reg.is_read ? fcca_pkg::ST_DONE : fcca_pkg::ST_IDLE;
            end
            fcca_pkg::ST_DONE: state_next = fcca_pkg::ST_IDLE;
            default:           state_next = fcca_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        case (state_reg)
            fcca_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                done = 1'b0;
            end
            fcca_pkg::ST_SWEEP:
            begin
                busy = 1'b1;
                done = 1'b0;
            end
            fcca_pkg::ST_DONE:
            begin
                busy = 1'b1;
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
                done = 1'b0;
            end
        endcase
    end

    assign status_word = acc_reg;

    always_comb
    begin
        cmd_next  = cmd_reg;
        mask_next = mask_reg;
        idx_next  = idx_reg;
        acc_next  = acc_reg;
        if (accept)
        begin
            cmd_next.is_read = action;
            cmd_next.raise   = fault_active;
            cmd_next.lock    = lock_class;
            cmd_next.blk     = blocked_fault;
            cmd_next.rel     = release_count;
            mask_next        = signal_mask[NUM_SIGNALS-1:0];
            idx_next         = '0;
            acc_next         = '0;
        end
        else if (sweeping)
        begin
            acc_next = step_acc;
            if (!last)
                idx_next = idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fcca_pkg::ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        mask_reg <= mask_next;
        acc_reg  <= acc_next;
    end

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy && (idx_reg == '0))
        else $error("accepted item did not start a sweep at signal zero");

    a_done_after_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(sweeping) && $past(last) && cmd_reg.is_read)
        else $error("result strobe not preceded by the last sweep step of a read");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && sweeping) |-> !cmd_reg.is_read)
        else $error("counter written during a read");

    a_event_no_done: assert property (@(posedge clk) disable iff (!rst_n)
        (sweeping && last && !cmd_reg.is_read) |=> !done && !busy)
        else $error("event produced a result or failed to return to idle");

endmodule

// ===== hw/rtl/fcca_count_bank.sv =====
// Storage of the runtime, blocked and locked counters with one indexed read and write port.
`timescale 1ns / 1ps

module fcca_count_bank #(
    parameter int NUM_SIGNALS = 32,
    parameter int COUNT_WIDTH = 16,
    parameter int IDX_W = 5
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [IDX_W-1:0]        idx,
    input  logic                    wr_en,
    input  fcca_pkg::class_t        wr_class,
    input  logic [COUNT_WIDTH-1:0]  wr_data,
    output logic [COUNT_WIDTH-1:0]  rd_run,
    output logic [COUNT_WIDTH-1:0]  rd_blk,
    output logic [COUNT_WIDTH-1:0]  rd_lock
);

    logic [COUNT_WIDTH-1:0] run_reg  [NUM_SIGNALS];
    logic [COUNT_WIDTH-1:0] blk_reg  [NUM_SIGNALS];
    logic [COUNT_WIDTH-1:0] lock_reg [NUM_SIGNALS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_SIGNALS; k++)
            begin
                run_reg[k]  <= '0;
                blk_reg[k]  <= '0;
                lock_reg[k] <= '0;
            end
        end
        else if (wr_en)
        begin
            case (wr_class)
                fcca_pkg::CLS_RUN:  run_reg[idx]  <= wr_data;
                fcca_pkg::CLS_BLK:  blk_reg[idx]  <= wr_data;
                fcca_pkg::CLS_LOCK: lock_reg[idx] <= wr_data;
                default:            run_reg[idx]  <= run_reg[idx];
            endcase
        end
    end

    assign rd_run  = run_reg[idx];
    assign rd_blk  = blk_reg[idx];
    assign rd_lock = lock_reg[idx];

endmodule

// ===== hw/rtl/fcca_step_unit.sv =====
// Shared per-signal unit: counter update arithmetic and status code selection for one signal.
`timescale 1ns / 1ps

module fcca_step_unit #(
    parameter int COUNT_WIDTH = 16,
    parameter int IDX_W = 5
) (
    input  fcca_pkg::cmd_t                 cmd,
    input  logic                           mask_bit,
    input  logic                           is_cert,
    input  logic [IDX_W-1:0]               idx,
    input  logic [1:0]                     variant,
    input  logic [fcca_pkg::WORD_W-1:0]    normal_word,
    input  logic [fcca_pkg::WORD_W-1:0]    acc_in,
    input  logic [COUNT_WIDTH-1:0]         cnt_run,
    input  logic [COUNT_WIDTH-1:0]         cnt_blk,
    input  logic [COUNT_WIDTH-1:0]         cnt_lock,
    output logic                           wr_en,
    output fcca_pkg::class_t               wr_class,
    output logic [COUNT_WIDTH-1:0]         wr_data,
    output logic [fcca_pkg::WORD_W-1:0]    acc_out
);

    localparam int EXT_W = (COUNT_WIDTH > fcca_pkg::REL_W) ? COUNT_WIDTH : fcca_pkg::REL_W;

    logic [fcca_pkg::TBL_IDX_W-1:0] tidx;
    logic [COUNT_WIDTH-1:0]         sel;
    logic [EXT_W-1:0]               sel_ext;
    logic [EXT_W-1:0]               opnd;
    logic [EXT_W-1:0]               result;
    logic                           apply;
    logic                           lk_nz;
    logic                           bk_nz;
    logic                           rt_nz;
    logic [fcca_pkg::WORD_W-1:0]    code;

    assign tidx = fcca_pkg::TBL_IDX_W'(idx);

    always_comb
    begin
        if (cmd.lock)
            wr_class = fcca_pkg::CLS_LOCK;
        else if (cmd.blk)
            wr_class = fcca_pkg::CLS_BLK;
        else
            wr_class = fcca_pkg::CLS_RUN;

        case (wr_class)
            fcca_pkg::CLS_LOCK: sel = cnt_lock;
            fcca_pkg::CLS_BLK:  sel = cnt_blk;
            default:            sel = cnt_run;
        endcase

        sel_ext = EXT_W'(sel);
        if (!cmd.raise && cmd.lock)
            opnd = EXT_W'(cmd.rel);
        else
            opnd = EXT_W'(1);

        result = cmd.raise ? (sel_ext + opnd) : (sel_ext - opnd);

        if (cmd.raise)
            apply = (sel != '1);
        else if (cmd.lock)
            apply = (sel != '0) && (cmd.rel != '0) && (sel_ext >= opnd);
        else
            apply = (sel != '0);

        wr_en   = !cmd.is_read && mask_bit && apply;
        wr_data = result[COUNT_WIDTH-1:0];
    end

    always_comb
    begin
        lk_nz = (cnt_lock != '0);
        bk_nz = (cnt_blk != '0);
        rt_nz = (cnt_run != '0);
        code  = '0;
        if (lk_nz)
            code = fcca_pkg::code_lock(variant, tidx);
        else if (!cmd.lock)
        begin
            case (variant)
                fcca_pkg::VAR_FIRST:
                begin
                    if (bk_nz)
                        code = fcca_pkg::code_blk(variant, tidx);
                    else if (rt_nz)
                        code = fcca_pkg::code_run(variant, tidx);
                end
                fcca_pkg::VAR_SECOND:
                begin
                    if (rt_nz)
                        code = fcca_pkg::code_run(variant, tidx);
                    else if (bk_nz)
                        code = fcca_pkg::code_blk(variant, tidx);
                end
                default: code = '0;
            endcase
        end

        acc_out = acc_in | code;
        if (is_cert && !lk_nz && (cmd.lock || !rt_nz))
            acc_out = acc_out | normal_word;
    end

endmodule
